/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hw/rtl/pba_pkg.sv */
// Package for the paged bump allocator: sizes, codes, payload and control types.
// Depends on nothing; used by every allocator module.
package pba_pkg;
	localparam int MaxPages   = 16;
	localparam int MaxRecords = 64;
	localparam int PgW  = $clog2(MaxPages);
	localparam int RecW = $clog2(MaxRecords);
	localparam int PgCntW  = $clog2(MaxPages + 1);
	localparam int RecCntW = $clog2(MaxRecords + 1);
	localparam logic [16:0] PageCap = 17'd65536;

	localparam logic [1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [1:0] FUNC_REALLOC = 2'd1;
	localparam logic [1:0] FUNC_CLEAR   = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_PAGE  = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_TOOLARGE = 3'd4;

	localparam logic [0:0] REG_PG_BYTES    = 1'd0;
	localparam logic [0:0] REG_ONE_PG_ONLY = 1'd1;

	typedef struct packed {
		logic [1:0]  func;
		logic [16:0] size;
		logic [3:0]  old_page;
		logic [15:0] old_offset;
	} req_t;

	typedef struct packed {
		logic [3:0]  page;
		logic [15:0] offset;
		logic [2:0]  status;
	} rsp_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;        // capture request
		logic clear_all;   // zero fills and record count
		logic pscan_init;  // start page scan at 0
		logic pscan_step;  // advance page scan
		logic rscan_init;  // start record scan
		logic rscan_step;  // advance record scan
		logic rec_rd;      // read record at hit index
		logic grow;        // commit grow in place
		logic open_new;    // commit into a newly opened page
		logic use_page;    // commit into scanned page
		logic rec_new;     // placement writes a new record (else updates hit)
		logic set_rsp;     // capture response
		logic [2:0] st;    // status for response
		logic keep_old;    // response is the old record place
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic [1:0] func;
		logic size_zero;
		logic too_large;
		logic tbl_full;
		logic pscan_done;  // scanned past open pages
		logic pfit;        // scanned page fits
		logic can_open;
		logic rscan_done;
		logic rhit;        // scanned record matches
		logic shrink;      // new size no larger than recorded
		logic can_grow;
	} sts_t;
endpackage

/* hw/rtl/pba_datapath.sv */
// Datapath of the paged bump allocator: page fills, record memory, scan pointers.
// Depends on pba_pkg; driven by pba_ctrl.
module pba_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pba_pkg::req_t        req,
	input  logic [16:0]          pg_bytes,
	input  logic                 one_pg_only,
	input  pba_pkg::cmd_t        cmd,
	output pba_pkg::sts_t        sts,
	output pba_pkg::rsp_t        rsp
);
	import pba_pkg::*;

	req_t                req_q;
	logic [16:0]         fill_q [MaxPages];
	logic [PgCntW-1:0]   open_q;
	logic [RecCntW-1:0]  cnt_q;
	logic [PgCntW-1:0]   pidx_q;
	logic [RecCntW-1:0]  ridx_q;
	logic [RecW-1:0]     hit_q;
	logic [3:0]          rpage_q;
	logic [15:0]         roff_q;
	logic [16:0]         rsize_q;
	logic [3:0]          mp_q [MaxRecords];
	logic [15:0]         mo_q [MaxRecords];
	logic [16:0]         ms_q [MaxRecords];
	logic [16:0]         eff_ps;
	logic [16:0]         cur_fill;
	logic [17:0]         fit_sum;
	logic [17:0]         grow_sum;
	logic [16:0]         end_q;
	logic                wr_en;
	logic [RecW-1:0]     wr_addr;
	logic [3:0]          wr_pg;
	logic [15:0]         wr_off;
	logic [PgW-1:0]      new_pg;
	logic [PgW-1:0]      scan_pg;
	logic [RecW-1:0]     rd_addr;

	assign eff_ps   = (pg_bytes > PageCap) ? PageCap : pg_bytes;
	assign scan_pg  = pidx_q[PgW-1:0];
	assign new_pg   = open_q[PgW-1:0];
	assign cur_fill = fill_q[scan_pg];
	assign fit_sum  = {1'b0, cur_fill} + {1'b0, req_q.size};
	assign grow_sum = {2'b0, roff_q} + {1'b0, req_q.size};

	assign sts.func       = req_q.func;
	assign sts.size_zero  = (req_q.size == '0);
	assign sts.too_large  = (req_q.size > eff_ps);
	assign sts.tbl_full   = (cnt_q >= RecCntW'(MaxRecords));
	assign sts.pscan_done = (pidx_q >= open_q);
	assign sts.pfit       = (fit_sum <= {1'b0, eff_ps});
	assign sts.can_open   = !one_pg_only && (open_q < PgCntW'(MaxPages));
	assign sts.rscan_done = (ridx_q >= cnt_q);
	// The data at hand is a live record only while ridx does not pass the count.
	assign sts.rhit       = (ridx_q <= cnt_q) && (rpage_q == req_q.old_page)
		&& (roff_q == req_q.old_offset);
	assign sts.shrink     = (req_q.size <= rsize_q);
	assign sts.can_grow   = (end_q == fill_q[rpage_q[PgW-1:0]])
		&& (grow_sum <= {1'b0, eff_ps});

	assign wr_en   = cmd.grow || cmd.open_new || cmd.use_page;
	assign wr_addr = cmd.rec_new ? cnt_q[RecW-1:0] : hit_q;
	assign wr_pg   = cmd.grow ? rpage_q : (cmd.open_new ? 4'(new_pg) : 4'(scan_pg));
	assign wr_off  = cmd.grow ? roff_q : (cmd.open_new ? 16'd0 : cur_fill[15:0]);
	assign rd_addr = cmd.rec_rd ? hit_q : (cmd.rscan_init ? '0 : ridx_q[RecW-1:0]);

	// Record memory: one write and one read port, read data registered.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mp_q[wr_addr] <= wr_pg;
			mo_q[wr_addr] <= wr_off;
			ms_q[wr_addr] <= req_q.size;
		end
		if (cmd.rscan_step || cmd.rscan_init || cmd.rec_rd) begin
			rpage_q <= mp_q[rd_addr];
			roff_q  <= mo_q[rd_addr];
			rsize_q <= ms_q[rd_addr];
		end
		end_q <= {1'b0, roff_q} + rsize_q;
		if (cmd.load) begin
			req_q <= req;
		end
		// hit_q follows the index of the record being read.
		if (cmd.rscan_init) begin
			hit_q <= '0;
		end else if (cmd.rscan_step) begin
			hit_q <= ridx_q[RecW-1:0];
		end
		if (cmd.set_rsp) begin
			rsp.status <= cmd.st;
			if (cmd.st != ST_OK
					|| (req_q.func != FUNC_ALLOC && req_q.func != FUNC_REALLOC)) begin
				rsp.page   <= '0;
				rsp.offset <= '0;
			end else if (cmd.keep_old) begin
				rsp.page   <= rpage_q;
				rsp.offset <= roff_q;
			end else begin
				rsp.page   <= wr_pg;
				rsp.offset <= wr_off;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxPages; i++) fill_q[i] <= '0;
			open_q <= PgCntW'(1);
			cnt_q  <= '0;
			pidx_q <= '0;
			ridx_q <= '0;
		end else begin
			if (cmd.clear_all) begin
				for (int i = 0; i < MaxPages; i++) fill_q[i] <= '0;
				cnt_q <= '0;
			end
			if (cmd.pscan_init) pidx_q <= '0;
			else if (cmd.pscan_step) pidx_q <= pidx_q + PgCntW'(1);
			// The read issues at index k and advances, so ridx leads the read data by one.
			if (cmd.rscan_init) ridx_q <= RecCntW'(1);
			else if (cmd.rscan_step) ridx_q <= ridx_q + RecCntW'(1);
			if (cmd.grow) fill_q[rpage_q[PgW-1:0]] <= grow_sum[16:0];
			if (cmd.use_page) fill_q[scan_pg] <= fit_sum[16:0];
			if (cmd.open_new) begin
				fill_q[new_pg] <= req_q.size;
				open_q <= open_q + PgCntW'(1);
			end
			if (wr_en && cmd.rec_new) cnt_q <= cnt_q + RecCntW'(1);
		end
	end
endmodule

/* hw/rtl/pba_ctrl.sv */
// Controller of the paged bump allocator: sequences scans and commits.
// Depends on pba_pkg and assert_macros.svh; drives pba_datapath.
`include "assert_macros.svh"
module pba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  pba_pkg::sts_t sts,
	output pba_pkg::cmd_t cmd
);
	import pba_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_RSCAN, S_RDHIT, S_RDEND, S_DECIDE, S_PSCAN, S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		unique case (state_q)
			S_IDLE: ;
			S_DECODE: begin
				priority if (sts.func == FUNC_CLEAR) begin
					cmd.clear_all = 1'b1;
					cmd.set_rsp   = 1'b1;
				end else if (sts.func == FUNC_ALLOC) begin
					cmd.pscan_init = 1'b1;
					if (sts.size_zero || sts.too_large) begin
						cmd.set_rsp = 1'b1;
						cmd.st = ST_TOOLARGE;
					end else if (sts.tbl_full) begin
						cmd.set_rsp = 1'b1;
						cmd.st = ST_FULL;
					end
				end else if (sts.func == FUNC_REALLOC) begin
					cmd.rscan_init = 1'b1;
					cmd.pscan_init = 1'b1;
				end else begin
					cmd.set_rsp = 1'b1;
				end
			end
			S_RSCAN: begin
				// Data at hand is record ridx-1.
				if (sts.rhit) begin
					cmd.rec_rd = 1'b0;
				end else if (sts.rscan_done) begin
					cmd.set_rsp = 1'b1;
					cmd.st = sts.size_zero ? ST_TOOLARGE : ST_NOTFOUND;
				end else begin
					cmd.rscan_step = 1'b1;
				end
			end
			S_RDHIT, S_RDEND: ;
			S_DECIDE: begin
				if (sts.size_zero) begin
					cmd.set_rsp = 1'b1;
					cmd.st = ST_TOOLARGE;
				end else if (sts.shrink) begin
					cmd.set_rsp  = 1'b1;
					cmd.keep_old = 1'b1;
				end else if (sts.too_large) begin
					cmd.set_rsp = 1'b1;
					cmd.st = ST_TOOLARGE;
				end else if (sts.can_grow) begin
					cmd.grow    = 1'b1;
					cmd.set_rsp = 1'b1;
				end
			end
			S_PSCAN: begin
				cmd.rec_new = (sts.func == FUNC_ALLOC);
				if (!sts.pscan_done) begin
					if (sts.pfit) begin
						cmd.use_page = 1'b1;
						cmd.set_rsp  = 1'b1;
					end else begin
						cmd.pscan_step = 1'b1;
					end
				end else if (sts.can_open) begin
					cmd.open_new = 1'b1;
					cmd.set_rsp  = 1'b1;
				end else begin
					cmd.set_rsp = 1'b1;
					cmd.st = ST_NO_PAGE;
				end
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_DECODE;
				S_DECODE: begin
					if (cmd.set_rsp) state_q <= S_DONE;
					else if (cmd.rscan_init) state_q <= S_RSCAN;
					else state_q <= S_PSCAN;
				end
				S_RSCAN: begin
					if (cmd.set_rsp) state_q <= S_DONE;
					else if (sts.rhit) state_q <= S_RDHIT;
				end
				S_RDHIT: state_q <= S_RDEND;
				S_RDEND: state_q <= S_DECIDE;
				S_DECIDE: state_q <= cmd.set_rsp ? S_DONE : S_PSCAN;
				S_PSCAN: if (cmd.set_rsp) state_q <= S_DONE;
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready, !out_valid_q && state_q == S_IDLE,
		"input ready outside idle")
	`ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == S_DONE, out_valid_q,
		"result not raised after done")
	`ASSERT_IMPL(a_one_commit, clk, arst_n, 1'b1,
		$countones({cmd.grow, cmd.open_new, cmd.use_page}) <= 1, "multiple commits")
endmodule

/* hw/rtl/paged_bump_allocator_unit.sv */
// Top level of the paged bump allocator: config registers, controller, datapath.
// Depends on pba_pkg, pba_ctrl and pba_datapath.
//
//  port group       direction  handshake
//  in (req_t)       in         in_valid / in_ready
//  out (rsp_t)      out        out_valid / out_ready
//  cfg              in         cfg_we, cfg_index, cfg_data
//
// One item is in flight at a time; a result waiting on out_ready holds off the next item.
// An allocate goes from decode to the page scan (every open page is tried in turn, then a new one
// is opened or refused) and then to done; errors caught at decode go straight to done.
// A reallocate scans records up to the match, passes RDHIT, RDEND and DECIDE, and scans pages
// when it moves; a miss ends after the record scan. The longest item moves after 64 records.
// Reset opens page zero, zeroes fills and empties the table; no clearing pass.
module paged_bump_allocator_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pba_pkg::req_t in,
	output logic          out_valid,
	input  logic          out_ready,
	output pba_pkg::rsp_t out,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [16:0]   cfg_data
);
	import pba_pkg::*;

	logic [16:0] pg_bytes_q;
	logic        one_pg_only_q;
	cmd_t        cmd;
	sts_t        sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_bytes_q    <= 17'd4096;
			one_pg_only_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PG_BYTES:    pg_bytes_q    <= cfg_data;
				REG_ONE_PG_ONLY: one_pg_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pba_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	pba_datapath u_dp (
		.clk, .arst_n, .req(in), .pg_bytes(pg_bytes_q), .one_pg_only(one_pg_only_q),
		.cmd, .sts, .rsp(out)
	);
endmodule

/* tb/paged_bump_allocator_unit_tb.sv */
// Testbench for the paged bump allocator: directed and random allocate, reallocate and clear
// items, checked against a behavioral predictor. Depends on pba_pkg and paged_bump_allocator_unit.
`timescale 1ns / 100ps
module paged_bump_allocator_unit_tb;
	import pba_pkg::*;

	localparam logic [1:0] FUNC_RESERVED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in;
	logic out_valid;
	logic out_ready;
	rsp_t out;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [16:0] cfg_data;

	paged_bump_allocator_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in(in),
		.out_valid(out_valid), .out_ready(out_ready), .out(out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic [16:0] pg_size;
	logic        one_page;
	logic [16:0] fill [MaxPages];
	int          open_cnt;
	logic [3:0]  r_page [MaxRecords];
	logic [15:0] r_off [MaxRecords];
	logic [16:0] r_size [MaxRecords];
	int          r_cnt;

	rsp_t expected_rsps[$];
	int   errors;
	int   rsp_seen;
	int   hold_req;
	int   hold_seen;
	int   hold_off;
	bit   stall_on;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $time);
	endtask

	function automatic int eff_size();
		return (pg_size > PageCap) ? int'(PageCap) : int'(pg_size);
	endfunction

	// Finds or opens a page and bumps its fill; returns 0 when no page may be used.
	function automatic bit place_bytes(input int sz, output int pg, output int off);
		int ps;
		ps = eff_size();
		for (int i = 0; i < open_cnt; i++) begin
			if (int'(fill[i]) + sz <= ps) begin
				pg = i;
				off = int'(fill[i]);
				fill[i] = 17'(int'(fill[i]) + sz);
				return 1'b1;
			end
		end
		if (one_page || open_cnt >= MaxPages)
			return 1'b0;
		pg = open_cnt;
		off = 0;
		fill[open_cnt] = 17'(sz);
		open_cnt++;
		return 1'b1;
	endfunction

	function automatic rsp_t predict_alloc(input req_t r);
		rsp_t res;
		int pg, off, ps, sz, hit, rp, rend;
		res = '0;
		pg = 0;
		off = 0;
		ps = eff_size();
		sz = int'(r.size);
		hit = -1;
		if (r.func == FUNC_CLEAR) begin
			for (int i = 0; i < MaxPages; i++)
				fill[i] = '0;
			r_cnt = 0;
		end else if (r.func == FUNC_ALLOC) begin
			if (sz == 0 || sz > ps)
				res.status = ST_TOOLARGE;
			else if (r_cnt >= MaxRecords)
				res.status = ST_FULL;
			else if (!place_bytes(sz, pg, off))
				res.status = ST_NO_PAGE;
			else begin
				r_page[r_cnt] = 4'(pg);
				r_off[r_cnt] = 16'(off);
				r_size[r_cnt] = 17'(sz);
				r_cnt++;
			end
		end else if (r.func == FUNC_REALLOC) begin
			for (int k = 0; k < r_cnt; k++) begin
				if (hit < 0 && r_page[k] == r.old_page && r_off[k] == r.old_offset)
					hit = k;
			end
			if (sz == 0)
				res.status = ST_TOOLARGE;
			else if (hit < 0)
				res.status = ST_NOTFOUND;
			else if (sz <= int'(r_size[hit])) begin
				pg = int'(r_page[hit]);
				off = int'(r_off[hit]);
			end else if (sz > ps)
				res.status = ST_TOOLARGE;
			else begin
				rp = int'(r_page[hit]);
				rend = int'(r_off[hit]) + int'(r_size[hit]);
				if (rend == int'(fill[rp]) && int'(r_off[hit]) + sz <= ps) begin
					fill[rp] = 17'(int'(r_off[hit]) + sz);
					r_size[hit] = 17'(sz);
					pg = rp;
					off = int'(r_off[hit]);
				end else if (!place_bytes(sz, pg, off))
					res.status = ST_NO_PAGE;
				else begin
					r_page[hit] = 4'(pg);
					r_off[hit] = 16'(off);
					r_size[hit] = 17'(sz);
				end
			end
		end
		if (res.status == ST_OK) begin
			res.page = 4'(pg);
			res.offset = 16'(off);
		end
		return res;
	endfunction

	// Sends one item after a random gap, mostly short.
	task automatic send_item(input logic [1:0] f, input int sz, input int opg, input int ooff);
		req_t r;
		int gap;
		r.func = f;
		r.size = 17'(sz);
		r.old_page = 4'(opg);
		r.old_offset = 16'(ooff);
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		in <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_rsps.push_back(predict_alloc(r));
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 17'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_PG_BYTES)
			pg_size = 17'(val);
		else
			one_page = val[0];
	endtask

	// Picks a realloc target: mostly a live record, sometimes a random place.
	task automatic send_realloc(input int sz);
		int k;
		if (r_cnt != 0 && $urandom_range(0, 7) != 0) begin
			k = $urandom_range(0, r_cnt - 1);
			send_item(FUNC_REALLOC, sz, int'(r_page[k]), int'(r_off[k]));
		end else
			send_item(FUNC_REALLOC, sz, $urandom_range(0, 15), $urandom_range(0, 65535));
	endtask

	function automatic int rand_size(input int ps);
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 131071);
			1: return ps;
			2: return ps + 1;
			default: return $urandom_range(1, (ps < 64) ? ps : ps / 8);
		endcase
	endfunction

	task automatic test_directed();
		send_item(FUNC_ALLOC, 0, 0, 0);
		send_item(FUNC_ALLOC, 131071, 0, 0);
		send_item(FUNC_ALLOC, 4097, 0, 0);
		send_item(FUNC_ALLOC, 4096, 0, 0);
		send_item(FUNC_ALLOC, 1, 0, 0);
		send_item(FUNC_ALLOC, 100, 0, 0);
		send_item(FUNC_REALLOC, 50, 1, 1);
		send_item(FUNC_REALLOC, 300, 1, 1);
		send_item(FUNC_REALLOC, 5000, 1, 0);
		send_item(FUNC_REALLOC, 4000, 1, 0);
		send_item(FUNC_REALLOC, 0, 1, 0);
		send_item(FUNC_REALLOC, 8, 15, 65535);
		send_item(FUNC_RESERVED, 131071, 15, 65535);
		send_item(FUNC_CLEAR, 0, 0, 0);
		send_item(FUNC_ALLOC, 10, 0, 0);
		drain();
	endtask

	// Fills every page and the record table to reach the no-page and table-full answers.
	task automatic test_limits();
		write_reg(REG_PG_BYTES, 1);
		send_item(FUNC_CLEAR, 0, 0, 0);
		for (int i = 0; i < 70; i++)
			send_item(FUNC_ALLOC, 1, 0, 0);
		drain();
		// Small items in a roomy page run the record table out before the pages.
		write_reg(REG_PG_BYTES, 4096);
		send_item(FUNC_CLEAR, 0, 0, 0);
		for (int i = 0; i < 66; i++)
			send_item(FUNC_ALLOC, 1, 0, 0);
		drain();
		write_reg(REG_PG_BYTES, 131071);
		send_item(FUNC_CLEAR, 0, 0, 0);
		send_item(FUNC_ALLOC, 65536, 0, 0);
		send_item(FUNC_ALLOC, 65537, 0, 0);
		drain();
		// Lowered page size leaves filled pages unusable.
		write_reg(REG_PG_BYTES, 16);
		write_reg(REG_ONE_PG_ONLY, 1);
		send_item(FUNC_ALLOC, 4, 0, 0);
		send_item(FUNC_CLEAR, 0, 0, 0);
		for (int i = 0; i < 6; i++)
			send_item(FUNC_ALLOC, 4, 0, 0);
		send_realloc(12);
		drain();
	endtask

	task automatic test_random(input int count, input int ps, input bit single);
		write_reg(REG_PG_BYTES, ps);
		write_reg(REG_ONE_PG_ONLY, single);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 19))
				0: send_item(FUNC_CLEAR, $urandom_range(0, 131071), $urandom_range(0, 15),
					$urandom_range(0, 65535));
				1: send_item(FUNC_RESERVED, $urandom_range(0, 131071), $urandom_range(0, 15),
					$urandom_range(0, 65535));
				2, 3, 4, 5, 6, 7, 8: send_realloc(rand_size(ps));
				default: send_item(FUNC_ALLOC, rand_size(ps), $urandom_range(0, 15),
					$urandom_range(0, 65535));
			endcase
		end
		drain();
	endtask

	// The receiver holds off while the sender keeps offering items.
	task automatic test_backpressure();
		hold_req++;
		for (int i = 0; i < 20; i++)
			send_item(FUNC_ALLOC, $urandom_range(1, 200), 0, 0);
		drain();
	endtask

	// Checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			rsp_seen++;
			if (expected_rsps.size() == 0)
				report("unexpected result", out.status, -1);
			else begin
				want = expected_rsps.pop_front();
				if (out.page !== want.page)
					report("page", out.page, want.page);
				if (out.offset !== want.offset)
					report("offset", out.offset, want.offset);
				if (out.status !== want.status)
					report("status", out.status, want.status);
			end
		end
	end

	// Receiver stalls: random gaps, an occasional long one, and a long counted hold-off
	// on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_off <= 0;
			hold_seen <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_off <= 300;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (stall_on) begin
			if ($urandom_range(0, 199) == 0) begin
				hold_off <= int'($urandom_range(10, 60));
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(0, 3) != 0);
		end else
			out_ready <= 1'b1;
	end

	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 0;
		stall_on = 1'b1;
		pg_size = 17'd4096;
		one_page = 1'b0;
		open_cnt = 1;
		r_cnt = 0;
		for (int i = 0; i < MaxPages; i++)
			fill[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limits();
		test_backpressure();
		test_random(200, 4096, 1'b0);
		test_random(150, 256, 1'b0);
		test_random(150, 1000, 1'b1);
		stall_on = 1'b0;
		test_random(150, 65536, 1'b0);
		stall_on = 1'b1;
		test_random(100, 17'h1FFFF, 1'b0);
		$display("Checked %0d results over allocate, reallocate and clear items", rsp_seen);
		$display("with page sizes from 1 to above 65536, single-page mode and output stalls.");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
